// ----- rtl/asm_pkg.sv -----
// asm_pkg: shared types and constants for the analog similarity metric.
// No dependencies.
package asm_pkg;
    localparam int FRACTION_BITS = 16;
    localparam int WEIGHT_FRACTION = 12;
    localparam int SUM_W = 48;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [32:0] ANGLE_FULL = 33'(360) << FRACTION_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_MEAN, S_ROOT, S_MUL, S_DIV, S_ADD, S_OUT
    } t_state;

    // multiply request between sequencer and the serial multiplier
    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [31:0] b;
    } t_mul_req;

    typedef struct packed {
        logic        done;
        logic [95:0] p;
    } t_mul_rsp;
endpackage

// ----- rtl/asm_serial_mul.sv -----
// asm_serial_mul: shift-and-add multiplier, one bit of b per cycle.
// Depends on asm_pkg.
module asm_serial_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  asm_pkg::t_mul_req i_req,
    output asm_pkg::t_mul_rsp o_rsp
);
    import asm_pkg::*;

    logic [95:0] r_acc, n_acc;
    logic [63:0] r_a, n_a;
    logic [31:0] r_b, n_b;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done, n_done;

    always_comb begin
        n_acc = r_acc; n_a = r_a; n_b = r_b; n_cnt = r_cnt;
        n_busy = r_busy; n_done = 1'b0;
        if (i_req.start) begin
            n_acc = '0; n_a = i_req.a; n_b = i_req.b; n_cnt = 6'd32; n_busy = 1'b1;
        end else if (r_busy) begin
            // acc = 2*acc + partial product: process msb first
            n_acc = {r_acc[94:0], 1'b0} + (r_b[31] ? {32'd0, r_a} : 96'd0);
            n_b = {r_b[30:0], 1'b0};
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_acc <= n_acc; r_a <= n_a; r_b <= n_b;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.p    = r_acc;
endmodule

// ----- rtl/analog_similarity_metric_top.sv -----
// analog_similarity_metric_top: weighted analog distance accumulator.
// Depends on asm_pkg and asm_serial_mul.
//
// channel | direction | handshake             | payload
// input   | in        | i_valid / o_stall     | window, mask, weight, spread, flags
// output  | out       | o_valid / i_stall     | o_similarity, o_saturated
//
// One transaction at a time. A skipped parameter goes from S_IDLE to S_OUT and back
// to S_IDLE. A counted one keeps o_stall high through the serial squares of each
// valid pair, the pair scan, mean, root, weight product, divide and add; the
// multiplier is bit-serial, and the mean, root and divide produce one bit per cycle.
// Reset (synchronous, active low) clears the sum, flag, output valid and sequencer.
// A result held by i_stall stays in the output register while new transactions
// are taken; only a following last parameter waits in S_OUT until it is taken.
module analog_similarity_metric_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_search_early,
    input  logic [31:0] i_search_centre,
    input  logic [31:0] i_search_late,
    input  logic [31:0] i_test_early,
    input  logic [31:0] i_test_centre,
    input  logic [31:0] i_test_late,
    input  logic [2:0]  i_pair_valid,
    input  logic        i_circular,
    input  logic [15:0] i_weight,
    input  logic [31:0] i_spread,
    input  logic        i_observation_valid,
    input  logic        i_last_parameter,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [47:0] o_similarity,
    output logic        o_saturated
);
    import asm_pkg::*;

    t_state r_state, n_state;
    logic [32:0] r_abs [3], n_abs [3];   // absolute (folded) differences
    logic [2:0]  r_mask, n_mask;
    logic [15:0] r_weight, n_weight;
    logic [31:0] r_spread, n_spread;
    logic        r_last, n_last;
    logic [1:0]  r_k, n_k;               // pair index
    logic [1:0]  r_count, n_count;
    logic [65:0] r_ssum, n_ssum;         // sum of squares
    logic [6:0]  r_i, n_i;               // serial loop counter
    logic [63:0] r_q, n_q;               // mean, then root work
    logic [1:0]  r_rem2, n_rem2;
    logic [65:0] r_rrem, n_rrem;         // root remainder
    logic [31:0] r_root, n_root;
    logic [47:0] r_num, n_num;
    logic [47:0] r_dq, n_dq;
    logic [47:0] r_drem, n_drem;
    logic        r_over, n_over;
    logic [47:0] r_sum, n_sum;
    logic        r_sat, n_sat;
    logic        r_ovalid, n_ovalid;
    logic [47:0] r_osim, n_osim;
    logic        r_osat, n_osat;
    logic        r_mwait, n_mwait;

    t_mul_req mul_req;
    t_mul_rsp mul_rsp;

    asm_serial_mul u_mul (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(mul_req), .o_rsp(mul_rsp));

    function automatic logic [32:0] fold(input logic [31:0] s, input logic [31:0] t,
                                         input logic circ);
        logic signed [32:0] d;
        logic [32:0] a, b;
        d = $signed({s[31], s}) - $signed({t[31], t});
        a = d[32] ? 33'(-d) : 33'(d);
        b = (a >= ANGLE_FULL) ? a - ANGLE_FULL : ANGLE_FULL - a;
        if (circ && b < a) a = b;
        return a;
    endfunction

    logic        acc_in;
    logic [65:0] rtrial;
    logic [2:0]  mtrial;
    logic [48:0] dtrial;
    logic [47:0] den_lo;
    logic [43:0] den_full;
    logic [47:0] sum_add;
    logic        sum_c;

    assign acc_in = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign den_full = {i_spread, 12'd0};
    assign den_lo = {4'd0, r_spread, 12'd0};

    always_comb begin
        n_state = r_state; n_abs = r_abs; n_mask = r_mask; n_weight = r_weight;
        n_spread = r_spread; n_last = r_last; n_k = r_k; n_count = r_count;
        n_ssum = r_ssum; n_i = r_i; n_q = r_q; n_rem2 = r_rem2; n_rrem = r_rrem;
        n_root = r_root; n_num = r_num; n_dq = r_dq; n_drem = r_drem; n_over = r_over;
        n_sum = r_sum; n_sat = r_sat; n_ovalid = r_ovalid; n_osim = r_osim;
        n_osat = r_osat; n_mwait = r_mwait;
        mul_req = '0;
        rtrial = '0; mtrial = '0; dtrial = '0; sum_add = '0; sum_c = 1'b0;
        if (r_ovalid && !i_stall) n_ovalid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (acc_in) begin
                    n_abs[0] = fold(i_search_early, i_test_early, i_circular);
                    n_abs[1] = fold(i_search_centre, i_test_centre, i_circular);
                    n_abs[2] = fold(i_search_late, i_test_late, i_circular);
                    n_mask = i_pair_valid; n_weight = i_weight; n_spread = i_spread;
                    n_last = i_last_parameter; n_k = 2'd0; n_count = 2'd0;
                    n_ssum = '0; n_mwait = 1'b0;
                    if (i_weight != 0 && i_observation_valid && i_spread != 0
                        && i_pair_valid != 0 && den_full != 0)
                        n_state = S_SQ;
                    else
                        n_state = S_OUT;
                end
            end
            S_SQ: begin
                if (!r_mwait) begin
                    if (r_k == 2'd3) begin
                        n_state = S_MEAN; n_i = 7'd66; n_q = '0; n_rem2 = '0;
                    end else if (r_mask[r_k]) begin
                        mul_req.start = 1'b1;
                        mul_req.a = {31'd0, r_abs[r_k]};
                        mul_req.b = r_abs[r_k][31:0];
                        n_mwait = 1'b1;
                    end else begin
                        n_k = r_k + 2'd1;
                    end
                end else if (mul_rsp.done) begin
                    // a*b[31:0] plus a*b[32]*2^32 covers the 33-bit square
                    n_ssum = r_ssum + 66'(mul_rsp.p)
                           + (r_abs[r_k][32] ? (66'(r_abs[r_k]) << 32) : 66'd0);
                    n_count = r_count + 2'd1;
                    n_k = r_k + 2'd1; n_mwait = 1'b0;
                end
            end
            S_MEAN: begin
                mtrial = {r_rem2, r_ssum[65]};
                n_ssum = {r_ssum[64:0], 1'b0};
                n_q = {r_q[62:0], 1'b0};
                if (mtrial >= {1'b0, r_count}) begin
                    n_rem2 = 2'(mtrial - {1'b0, r_count});
                    n_q[0] = 1'b1;
                end else begin
                    n_rem2 = mtrial[1:0];
                end
                n_i = r_i - 7'd1;
                if (r_i == 7'd1) begin
                    n_state = S_ROOT; n_i = 7'd32; n_rrem = '0; n_root = '0;
                end
            end
            S_ROOT: begin
                // two bits of radicand per cycle
                rtrial = {r_rrem[63:0], r_q[63:62]};
                n_q = {r_q[61:0], 2'b00};
                if (rtrial >= {32'd0, r_root, 2'b01}) begin
                    n_rrem = rtrial - {32'd0, r_root, 2'b01};
                    n_root = {r_root[30:0], 1'b1};
                end else begin
                    n_rrem = rtrial;
                    n_root = {r_root[30:0], 1'b0};
                end
                n_i = r_i - 7'd1;
                if (r_i == 7'd1) begin
                    n_state = S_MUL; n_mwait = 1'b0;
                end
            end
            S_MUL: begin
                if (!r_mwait) begin
                    mul_req.start = 1'b1;
                    mul_req.a = {48'd0, r_weight};
                    mul_req.b = r_root;
                    n_mwait = 1'b1;
                end else if (mul_rsp.done) begin
                    n_num = mul_rsp.p[47:0];
                    n_mwait = 1'b0; n_state = S_DIV; n_i = 7'd64;
                    n_dq = '0; n_drem = '0; n_over = 1'b0;
                end
            end
            S_DIV: begin
                dtrial = {r_drem, (r_i > 7'd16) ? r_num[47] : 1'b0};
                if (r_i > 7'd16) n_num = {r_num[46:0], 1'b0};
                if (r_dq[47]) n_over = 1'b1;
                n_dq = {r_dq[46:0], 1'b0};
                if (dtrial >= {1'b0, den_lo}) begin
                    n_drem = 48'(dtrial - {1'b0, den_lo});
                    n_dq[0] = 1'b1;
                end else begin
                    n_drem = dtrial[47:0];
                end
                n_i = r_i - 7'd1;
                if (r_i == 7'd1) n_state = S_ADD;
            end
            S_ADD: begin
                {sum_c, sum_add} = {1'b0, r_sum} + {1'b0, (r_over ? SUM_MAX : r_dq)};
                if (r_over) n_sat = 1'b1;
                if (sum_c) begin
                    n_sum = SUM_MAX; n_sat = 1'b1;
                end else begin
                    n_sum = sum_add;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                // a new result waits here while the previous one is still stalled
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (!(r_ovalid && i_stall)) begin
                    n_osim = n_sum; n_osat = n_sat; n_ovalid = 1'b1;
                    n_sum = '0; n_sat = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_sum <= '0; r_sat <= 1'b0; r_ovalid <= 1'b0;
            r_mwait <= 1'b0;
        end else begin
            r_state <= n_state; r_sum <= n_sum; r_sat <= n_sat; r_ovalid <= n_ovalid;
            r_mwait <= n_mwait;
        end
        r_abs <= n_abs; r_mask <= n_mask; r_weight <= n_weight; r_spread <= n_spread;
        r_last <= n_last; r_k <= n_k; r_count <= n_count; r_ssum <= n_ssum;
        r_i <= n_i; r_q <= n_q; r_rem2 <= n_rem2; r_rrem <= n_rrem; r_root <= n_root;
        r_num <= n_num; r_dq <= n_dq; r_drem <= n_drem; r_over <= n_over;
        r_osim <= n_osim; r_osat <= n_osat;
    end

    assign o_valid = r_ovalid;
    assign o_similarity = r_osim;
    assign o_saturated = r_osat;
endmodule

// ----- rtl/asm_checker.sv -----
// asm_checker: port-level assertions for the similarity metric.
// Depends on asm_pkg and analog_similarity_metric_top ports; bound below.
module asm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [47:0] o_similarity,
    input logic        o_saturated
);
    import asm_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_similarity) && $stable(o_saturated))
        else $error("result changed while stalled");
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown({o_valid, o_stall}))
        else $error("handshake output unknown");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("no busy after accept");
    a_sat_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |-> o_similarity == SUM_MAX)
        else $error("saturated result below maximum");
endmodule

bind analog_similarity_metric_top asm_checker u_asm_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_similarity(o_similarity),
    .o_saturated(o_saturated)
);

// ----- sim/tb_analog_similarity_metric_top.sv -----
// Self-checking testbench for analog_similarity_metric_top: directed and random
// parameter transactions, with a scoreboard class that predicts each candidate sum.
// Depends on asm_pkg and the RTL of analog_similarity_metric_top.
module tb_analog_similarity_metric_top;
    timeunit 1ns;
    timeprecision 1ps;
    import asm_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int DRAIN_CYCLES = 600;
    localparam int RANDOM_ITEMS = 1430;

    // one parameter transaction as seen on the input ports
    typedef struct {
        logic [31:0] srch [3];
        logic [31:0] tst [3];
        logic [2:0]  mask;
        logic        circ;
        logic [15:0] weight;
        logic [31:0] spread;
        logic        obs;
        logic        last;
    } t_param;

    // Running model of the candidate accumulator plus a queue of pending sums.
    class sim_scoreboard;
        logic [SUM_W-1:0] acc_sum;
        logic             acc_over;
        logic [SUM_W-1:0] sum_q [$];
        logic             sat_q [$];

        function new();
            acc_sum = '0;
            acc_over = 1'b0;
        endfunction

        static function logic [63:0] int_sqrt(logic [63:0] x);
            logic [63:0] res;
            logic [63:0] bitv;
            res = '0;
            bitv = 64'd1 << 62;
            while (bitv > x) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (x >= res + bitv) begin
                    x = x - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        function void note_param(t_param p);
            logic signed [32:0] d;
            logic [32:0]        a, b;
            logic [65:0]        sq_sum, mean;
            logic [63:0]        root;
            logic [47:0]        num;
            logic [79:0]        quot;
            logic [47:0]        term;
            int                 cnt;
            if (p.weight != 0 && p.obs && p.spread != 0 && p.mask != 0) begin
                sq_sum = '0;
                cnt = 0;
                for (int k = 0; k < 3; k++) begin
                    if (p.mask[k]) begin
                        d = $signed({p.srch[k][31], p.srch[k]})
                          - $signed({p.tst[k][31], p.tst[k]});
                        a = d[32] ? 33'(-d) : 33'(d);
                        if (p.circ) begin
                            b = (a >= ANGLE_FULL) ? a - ANGLE_FULL : ANGLE_FULL - a;
                            if (b < a) a = b;
                        end
                        sq_sum = sq_sum + 66'(64'(a) * 64'(a));
                        cnt++;
                    end
                end
                mean = sq_sum / 66'(cnt);
                root = int_sqrt(mean[63:0]);
                num = 48'(p.weight) * root[31:0];
                quot = ({32'd0, num} << FRACTION_BITS)
                     / (80'(p.spread) << WEIGHT_FRACTION);
                if (quot > 80'(SUM_MAX)) begin
                    term = SUM_MAX;
                    acc_over = 1'b1;
                end else begin
                    term = quot[47:0];
                end
                if (term > SUM_MAX - acc_sum) begin
                    acc_sum = SUM_MAX;
                    acc_over = 1'b1;
                end else begin
                    acc_sum = acc_sum + term;
                end
            end
            if (p.last) begin
                sum_q.push_back(acc_sum);
                sat_q.push_back(acc_over);
                acc_sum = '0;
                acc_over = 1'b0;
            end
        endfunction

        // returns 1 when the result matches the oldest pending sum
        function bit check_sum(logic [47:0] sim, logic sat, output string msg);
            logic [47:0] es;
            logic        ev;
            if (sum_q.size() == 0) begin
                msg = $sformatf("unexpected result sim=%h sat=%b", sim, sat);
                return 1'b0;
            end
            es = sum_q.pop_front();
            ev = sat_q.pop_front();
            if (sim !== es || sat !== ev) begin
                msg = $sformatf("result sim=%h sat=%b, want sim=%h sat=%b",
                                sim, sat, es, ev);
                return 1'b0;
            end
            msg = "";
            return 1'b1;
        endfunction

        function int pending();
            return sum_q.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_search_early = '0, i_search_centre = '0, i_search_late = '0;
    logic [31:0] i_test_early = '0, i_test_centre = '0, i_test_late = '0;
    logic [2:0]  i_pair_valid = '0;
    logic        i_circular = 1'b0;
    logic [15:0] i_weight = '0;
    logic [31:0] i_spread = '0;
    logic        i_observation_valid = 1'b0;
    logic        i_last_parameter = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [47:0] o_similarity;
    logic        o_saturated;

    sim_scoreboard sb = new();
    int  mismatches = 0;
    int  idle_cycles = 0;
    int  cycle_no = 0;
    bit  quiet = 1'b0;   // no idling on either side while set

    analog_similarity_metric_top u_top (.*);

    always #1 i_clk = ~i_clk;

    task automatic report(string msg);
        $display("mismatch @%0d: %s", cycle_no, msg);
        mismatches++;
    endtask

    // Monitors sample before the edge's NBA updates land.
    always @(posedge i_clk) begin
        t_param p;
        string  msg;
        cycle_no++;
        idle_cycles++;
        if (i_rst_n && i_valid && !o_stall) begin
            p.srch = '{i_search_early, i_search_centre, i_search_late};
            p.tst = '{i_test_early, i_test_centre, i_test_late};
            p.mask = i_pair_valid;
            p.circ = i_circular;
            p.weight = i_weight;
            p.spread = i_spread;
            p.obs = i_observation_valid;
            p.last = i_last_parameter;
            sb.note_param(p);
            idle_cycles = 0;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (!sb.check_sum(o_similarity, o_saturated, msg)) report(msg);
            idle_cycles = 0;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver back-pressure: i_stall is raised about 6 percent of the time, never while quiet.
    always @(posedge i_clk)
        i_stall <= !quiet && ($urandom_range(0, 99) < 6);

    // Drives one transaction and returns at the edge where it was taken.
    task automatic send_param(t_param p);
        while (!quiet && $urandom_range(0, 99) < 6) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_search_early <= p.srch[0];
        i_search_centre <= p.srch[1];
        i_search_late <= p.srch[2];
        i_test_early <= p.tst[0];
        i_test_centre <= p.tst[1];
        i_test_late <= p.tst[2];
        i_pair_valid <= p.mask;
        i_circular <= p.circ;
        i_weight <= p.weight;
        i_spread <= p.spread;
        i_observation_valid <= p.obs;
        i_last_parameter <= p.last;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_value(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
            2: return 32'($signed($urandom_range(0, 720 << 16)) - (32'sd360 << 16));
            default: return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        endcase
    endfunction

    function automatic t_param rand_param();
        t_param p;
        int     mode;
        int     r;
        mode = $urandom_range(0, 9);
        mode = (mode < 3) ? 0 : (mode < 6) ? 1 : (mode < 9) ? 2 : 3;
        for (int k = 0; k < 3; k++) begin
            p.srch[k] = rand_value(mode);
            p.tst[k] = ($urandom_range(0, 3) == 0) ? rand_value(3) : rand_value(mode);
        end
        r = $urandom_range(0, 19);
        p.mask = (r == 0) ? 3'd0 : (r < 10) ? 3'd7 : 3'($urandom_range(1, 7));
        p.circ = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 19);
        p.weight = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom());
        r = $urandom_range(0, 19);
        p.spread = (r == 0) ? 32'd0 : (r < 3) ? 32'($urandom_range(1, 16))
                 : (r < 5) ? 32'hFFFF_FFFF : $urandom();
        p.obs = ($urandom_range(0, 15) != 0);
        p.last = ($urandom_range(0, 3) == 0);
        return p;
    endfunction

    function automatic t_param make_param(logic [31:0] s, logic [31:0] t, logic [2:0] m,
                                          logic c, logic [15:0] w, logic [31:0] sp,
                                          logic ob, logic l);
        t_param p;
        p.srch = '{s, s, s};
        p.tst = '{t, t, t};
        p.mask = m;
        p.circ = c;
        p.weight = w;
        p.spread = sp;
        p.obs = ob;
        p.last = l;
        return p;
    endfunction

    initial begin
        t_param p;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, skip conditions, angles, clipping
        send_param(make_param(32'h7FFF_FFFF, 32'h8000_0000, 3'd7, 1'b0, 16'hFFFF,
                              32'd1, 1'b1, 1'b1));          // term clip
        send_param(make_param(32'h8000_0000, 32'h7FFF_FFFF, 3'd1, 1'b1, 16'hFFFF,
                              32'hFFFF_FFFF, 1'b1, 1'b1));
        send_param(make_param(32'd10 << 16, 32'd350 << 16, 3'd7, 1'b1, 16'h1000,
                              32'h0001_0000, 1'b1, 1'b1));  // wraps through 360
        send_param(make_param(32'd0, 32'd360 << 16, 3'd2, 1'b1, 16'h1000,
                              32'h0001_0000, 1'b1, 1'b1));
        send_param(make_param(32'd0, 32'd180 << 16, 3'd4, 1'b1, 16'h1000,
                              32'h0001_0000, 1'b1, 1'b1));
        send_param(make_param(32'd5 << 16, 32'd1 << 16, 3'd0, 1'b0, 16'h1000,
                              32'h0001_0000, 1'b1, 1'b1));  // no valid pair
        send_param(make_param(32'd5 << 16, 32'd1 << 16, 3'd7, 1'b0, 16'd0,
                              32'h0001_0000, 1'b1, 1'b0));  // zero weight
        send_param(make_param(32'd5 << 16, 32'd1 << 16, 3'd7, 1'b0, 16'h1000,
                              32'd0, 1'b1, 1'b0));          // zero spread
        send_param(make_param(32'd5 << 16, 32'd1 << 16, 3'd7, 1'b0, 16'h1000,
                              32'h0001_0000, 1'b0, 1'b0));  // no observation
        send_param(make_param(32'd5 << 16, 32'd1 << 16, 3'd3, 1'b0, 16'h1000,
                              32'h0001_0000, 1'b1, 1'b1));
        for (int i = 0; i < 4; i++)                         // sum clip
            send_param(make_param(32'h7FFF_FFFF, 32'h8000_0000, 3'd7, 1'b0, 16'hFFFF,
                                  32'd2, 1'b1, i == 3));
        send_param(make_param(32'd0, 32'd0, 3'd7, 1'b0, 16'hFFFF, 32'hFFFF_FFFF,
                              1'b1, 1'b1));
        send_param(make_param(32'hFFFF_FFFF, 32'd0, 3'd5, 1'b1, 16'h0001, 32'd1,
                              1'b1, 1'b1));

        // random part; quiet stretch early on, a full drain halfway
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            quiet = (i >= 200 && i < 400);
            if (i == RANDOM_ITEMS / 2) begin
                i_valid <= 1'b0;
                while (sb.pending() != 0) @(posedge i_clk);
                repeat (DRAIN_CYCLES) @(posedge i_clk);
            end
            p = rand_param();
            if (i == RANDOM_ITEMS - 1) p.last = 1'b1;
            send_param(p);
        end
        i_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
